### design/adam_pkg.sv
// Package for the Adam optimiser update block: payload structs, register indexes,
// controller states and the controller/datapath command and status types.
// No dependencies.
package adam_pkg;

	localparam int unsigned DW = 32;
	localparam int unsigned IDX_W = 12;

	typedef struct packed {
		logic [IDX_W-1:0] element_index;
		logic signed [DW-1:0] gradient;
		logic signed [DW-1:0] param_value;
		logic begin_step;
	} adam_in_t;

	typedef struct packed {
		logic [IDX_W-1:0] result_index;
		logic signed [DW-1:0] new_param_value;
		logic saturated;
	} adam_out_t;

	localparam logic [1:0] REG_LR = 2'd0;
	localparam logic [1:0] REG_BETA1 = 2'd1;
	localparam logic [1:0] REG_BETA2 = 2'd2;
	localparam logic [1:0] REG_EPS = 2'd3;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_MOM,
		ST_DIVM,
		ST_DIVV,
		ST_SQRT,
		ST_DIVU,
		ST_FINAL,
		ST_OUT
	} adam_state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic clear_wr;
		logic load;
		logic moments;
		logic start_divm;
		logic start_divv;
		logic start_sqrt;
		logic start_divu;
		logic finish;
	} adam_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic clear_done;
		logic unit_done;
	} adam_sts_t;

endpackage

### design/adam_ctrl.sv
// Controller state machine for the Adam optimiser update block.
// Depends on adam_pkg.
module adam_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	output adam_pkg::adam_cmd_t cmd,
	input  adam_pkg::adam_sts_t sts
);
	import adam_pkg::*;

	adam_state_t state_q, state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clear_wr = 1'b1;
				if (sts.clear_done) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				state_d = ST_MOM;
			end
			ST_MOM: begin
				cmd.moments = 1'b1;
				cmd.start_divm = 1'b1;
				state_d = ST_DIVM;
			end
			ST_DIVM: begin
				if (sts.unit_done) begin
					cmd.start_divv = 1'b1;
					state_d = ST_DIVV;
				end
			end
			ST_DIVV: begin
				if (sts.unit_done) begin
					cmd.start_sqrt = 1'b1;
					state_d = ST_SQRT;
				end
			end
			ST_SQRT: begin
				if (sts.unit_done) begin
					cmd.start_divu = 1'b1;
					state_d = ST_DIVU;
				end
			end
			ST_DIVU: begin
				if (sts.unit_done) state_d = ST_FINAL;
			end
			ST_FINAL: begin
				cmd.finish = 1'b1;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				out_valid = 1'b1;
				if (out_ready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

`ifndef SYNTHESIS
	// Only one long-running unit is started at a time
	assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.start_divm, cmd.start_divv, cmd.start_sqrt, cmd.start_divu}))
		else $error("two units started together");
	// An accepted item always leads into the read state
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == ST_READ))
		else $error("accept did not start processing");
	// No input is taken while a result waits
	assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input and output open together");
`endif
endmodule

### design/adam_dpath.sv
// Datapath of the Adam optimiser update: moment memories, step powers,
// a shared restoring divider and square root unit. Depends on adam_pkg.
module adam_dpath #(
	parameter int unsigned NUM_ELEMENTS = 4096
) (
	input  logic clk,
	input  logic arst_n,
	input  adam_pkg::adam_in_t in_item,
	input  logic cfg_we,
	input  logic [1:0] cfg_idx,
	input  logic [23:0] cfg_data,
	input  adam_pkg::adam_cmd_t cmd,
	output adam_pkg::adam_sts_t sts,
	output adam_pkg::adam_out_t out_item
);
	import adam_pkg::*;

	localparam int unsigned AW = (NUM_ELEMENTS > 1) ? $clog2(NUM_ELEMENTS) : 1;

	logic [23:0] lr_q;
	logic [15:0] b1_q, b2_q, eps_q;
	logic [31:0] p1_q, p2_q;

	logic [31:0] mmem [NUM_ELEMENTS];
	logic [31:0] vmem [NUM_ELEMENTS];
	logic [AW:0] clr_q;
	logic [AW-1:0] addr_q;
	logic [IDX_W-1:0] idx_q;
	logic signed [31:0] g_q, p_q;
	logic [31:0] mrd_q, vrd_q;

	logic mneg_q, sat_q;
	logic [31:0] mmag_q, v_q, mh_q;
	logic [32:0] upd_q;
	adam_out_t out_q;

	// Unit: 0 = divide, 1 = sqrt
	logic unit_sqrt_q, busy_q;
	logic [6:0] cnt_q;
	logic [63:0] num_q;   // dividend / radicand shifted
	logic [63:0] quo_q;   // quotient / root
	logic [64:0] rem_q;
	logic [63:0] dvs_q;
	logic [1:0] job_q;    // 0 m_hat,1 v_hat,2 sqrt,3 update

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lr_q <= 24'd16777;
			b1_q <= 16'd58982;
			b2_q <= 16'd65470;
			eps_q <= 16'd1;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_LR: lr_q <= cfg_data;
				REG_BETA1: b1_q <= cfg_data[15:0];
				REG_BETA2: b2_q <= cfg_data[15:0];
				REG_EPS: eps_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// Clearing sweep counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clear_wr && clr_q != (AW+1)'(NUM_ELEMENTS)) begin
			clr_q <= clr_q + 1'b1;
		end
	end
	assign sts.clear_done = (clr_q == (AW+1)'(NUM_ELEMENTS));

	// Moment arithmetic
	logic signed [63:0] msum;
	logic signed [31:0] mnew;
	logic [31:0] gmag;
	logic [63:0] gsq_q, vsum;
	logic [47:0] vnew;
	always_comb begin
		msum = $signed({48'd0, b1_q}) * $signed({{32{mrd_q[31]}}, mrd_q})
			+ $signed({47'd0, 17'(17'h10000 - {1'b0, b1_q})}) * $signed({{32{g_q[31]}}, g_q});
		mnew = 32'(msum >>> 16);
		gmag = g_q[31] ? 32'(-g_q) : g_q;
		vsum = {48'd0, b2_q} * {32'd0, vrd_q} + {47'd0, 17'(17'h10000 - {1'b0, b2_q})} * gsq_q;
		vnew = vsum[63:16];
	end

	// Square the gradient in a register ahead of the moment update
	always_ff @(posedge clk) begin
		gsq_q <= ({32'd0, gmag} * {32'd0, gmag}) >> 16;
	end

	// Memories
	always_ff @(posedge clk) begin
		if (cmd.clear_wr && !sts.clear_done) begin
			mmem[clr_q[AW-1:0]] <= '0;
			vmem[clr_q[AW-1:0]] <= '0;
		end else if (cmd.moments) begin
			mmem[addr_q] <= mnew;
			vmem[addr_q] <= (vnew > 48'hFFFF_FFFF) ? 32'hFFFF_FFFF : vnew[31:0];
		end
		mrd_q <= mmem[addr_q];
		vrd_q <= vmem[addr_q];
	end

	// Load item and step powers
	logic [47:0] p1n, p2n;
	assign p1n = {16'd0, p1_q} * {32'd0, b1_q};
	assign p2n = {16'd0, p2_q} * {32'd0, b2_q};
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p1_q <= 32'h8000_0000;
			p2_q <= 32'h8000_0000;
		end else if (cmd.load && in_item.begin_step) begin
			p1_q <= p1n[47:16];
			p2_q <= p2n[47:16];
		end
	end
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			addr_q <= AW'(in_item.element_index % NUM_ELEMENTS);
			idx_q <= in_item.element_index;
			g_q <= in_item.gradient;
			p_q <= in_item.param_value;
		end
	end

	logic [31:0] d1, d2;
	assign d1 = 32'h8000_0000 - p1_q;
	assign d2 = 32'h8000_0000 - p2_q;

	// Corrected second moment straight from the unit
	logic [31:0] vh_fin;
	assign vh_fin = (d2 == 32'd0) ? v_q
		: ((quo_q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : quo_q[31:0]);

	// Denominator from the root still held in the unit
	logic [33:0] den;
	always_comb begin
		den = {2'b0, quo_q[31:0]} + {18'd0, eps_q};
		if (den == 34'd0) den = 34'd1;
	end

	// Shared iterative unit, one bit a cycle
	logic [64:0] rtry;
	logic [64:0] rsh;
	always_comb begin
		rsh = unit_sqrt_q ? {rem_q[62:0], num_q[63:62]} : {rem_q[63:0], num_q[63]};
		rtry = unit_sqrt_q ? (rsh - {quo_q[62:0], 2'b01}) : (rsh - {1'b0, dvs_q});
	end
	assign sts.unit_done = busy_q && cnt_q == 7'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (cmd.start_divm || cmd.start_divv || cmd.start_sqrt || cmd.start_divu) begin
			busy_q <= 1'b1;
		end else if (sts.unit_done) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		// Launch jobs
		if (cmd.moments) begin
			mneg_q <= mnew[31];
			mmag_q <= mnew[31] ? 32'(-mnew) : mnew;
			v_q <= (vnew > 48'hFFFF_FFFF) ? 32'hFFFF_FFFF : vnew[31:0];
			sat_q <= (vnew > 48'hFFFF_FFFF);
			unit_sqrt_q <= 1'b0;
			job_q <= 2'd0;
			cnt_q <= 7'd64;
			num_q <= {1'b0, (mnew[31] ? 32'(-mnew) : mnew), 31'd0};
			dvs_q <= {32'd0, d1};
			rem_q <= '0;
			quo_q <= '0;
		end else if (cmd.start_divv) begin
			unit_sqrt_q <= 1'b0;
			job_q <= 2'd1;
			cnt_q <= 7'd64;
			num_q <= {1'b0, v_q, 31'd0};
			dvs_q <= {32'd0, d2};
			rem_q <= '0;
			quo_q <= '0;
		end else if (cmd.start_sqrt) begin
			unit_sqrt_q <= 1'b1;
			job_q <= 2'd2;
			cnt_q <= 7'd32;
			num_q <= {16'd0, vh_fin, 16'd0};
			rem_q <= '0;
			quo_q <= '0;
		end else if (cmd.start_divu) begin
			unit_sqrt_q <= 1'b0;
			job_q <= 2'd3;
			cnt_q <= 7'd64;
			num_q <= {32'd0, mh_q} * {40'd0, lr_q};
			dvs_q <= {22'd0, den, 8'd0};
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q && cnt_q != 7'd0) begin
			cnt_q <= cnt_q - 1'b1;
			num_q <= unit_sqrt_q ? {num_q[61:0], 2'b00} : {num_q[62:0], 1'b0};
			if (!rtry[64]) begin
				rem_q <= rtry;
				quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rem_q <= rsh;
				quo_q <= {quo_q[62:0], 1'b0};
			end
		end

		// Collect unit results
		if (sts.unit_done) begin
			case (job_q)
				2'd0: begin
					if (d1 == 32'd0) begin
						mh_q <= mmag_q;
					end else if (quo_q > {32'd0, 32'h7FFF_FFFF} + {63'd0, mneg_q}) begin
						mh_q <= 32'h7FFF_FFFF + {31'd0, mneg_q};
						sat_q <= 1'b1;
					end else begin
						mh_q <= quo_q[31:0];
					end
				end
				2'd1: begin
					if (d2 != 32'd0 && quo_q > 64'hFFFF_FFFF) sat_q <= 1'b1;
				end
				2'd3: upd_q <= (quo_q > 64'h1_FFFF_FFFF) ? 33'h1_FFFF_FFFF : quo_q[32:0];
				default: ;
			endcase
		end
	end

	// Final subtraction with saturation
	logic signed [34:0] np;
	always_comb begin
		np = mneg_q ? ({{3{p_q[31]}}, p_q} + $signed({2'b0, upd_q}))
			: ({{3{p_q[31]}}, p_q} - $signed({2'b0, upd_q}));
	end
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_q.result_index <= idx_q;
			if (np > 35'sh0_7FFF_FFFF) begin
				out_q.new_param_value <= 32'h7FFF_FFFF;
				out_q.saturated <= 1'b1;
			end else if (np < -35'sh0_8000_0000) begin
				out_q.new_param_value <= 32'h8000_0000;
				out_q.saturated <= 1'b1;
			end else begin
				out_q.new_param_value <= np[31:0];
				out_q.saturated <= sat_q;
			end
		end
	end
	assign out_item = out_q;

`ifndef SYNTHESIS
	// The unit never runs during the clearing sweep
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear_wr |-> !busy_q)
		else $error("unit busy while clearing");
	// Unit finishes exactly when its counter runs out
	assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && cnt_q == 7'd1) |=> sts.unit_done)
		else $error("unit count slip");
	// Step powers never exceed one
	assert property (@(posedge clk) disable iff (!arst_n)
		(p1_q <= 32'h8000_0000) && (p2_q <= 32'h8000_0000))
		else $error("power above one");
`endif
endmodule

### design/adam_optimizer_update.sv
// Adam optimiser element update: one item in, one result out.
// Two 64-step divisions, a 32-step square root and a 64-step division share one
// bit-serial unit beside read, moment and final stages; a new item is taken the
// cycle after the result leaves, so only one item is in flight at a time.
// After reset a clearing sweep over all NUM_ELEMENTS entries zeroes both moment
// memories before the first item is accepted; configuration writes are taken throughout.
module adam_optimizer_update #(
	parameter int unsigned NUM_ELEMENTS = 4096
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  adam_pkg::adam_in_t in_data,
	output logic out_valid,
	input  logic out_ready,
	output adam_pkg::adam_out_t out_data,
	input  logic cfg_we,
	input  logic [1:0] cfg_idx,
	input  logic [23:0] cfg_data
);
	import adam_pkg::*;

	adam_cmd_t cmd;
	adam_sts_t sts;

	adam_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready),
		.cmd(cmd), .sts(sts)
	);

	adam_dpath #(.NUM_ELEMENTS(NUM_ELEMENTS)) u_dpath (
		.clk(clk), .arst_n(arst_n), .in_item(in_data),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
		.cmd(cmd), .sts(sts), .out_item(out_data)
	);
endmodule
